// ----- rtl/mbd_pkg.sv -----
// Package for the 2x2 box-filter mipmap downsampler.
// Holds the lane layout, channel widths, register indexes and defaults.
// No dependencies.
package mbd_pkg;

  // Channel and dimension widths.
  localparam int CH_W   = 8;
  localparam int LANE_W = CH_W + 1;
  localparam int DIM_W  = 13;
  localparam int HALF_W = DIM_W - 1;

  // Default for the widest source row the line store covers.
  localparam int MBD_MAX_WIDTH = 4096;

  // Alpha threshold and the two alpha results.
  localparam logic [CH_W-1:0] ALPHA_THRESH = 8'd128;
  localparam logic [CH_W-1:0] ALPHA_FULL   = 8'd255;
  localparam logic [CH_W-1:0] ALPHA_NONE   = 8'd0;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  // Horizontal pair sum of one RGBA pixel pair, red in the low lane.
  typedef struct packed {
    logic [LANE_W-1:0] alpha;
    logic [LANE_W-1:0] blue;
    logic [LANE_W-1:0] green;
    logic [LANE_W-1:0] red;
  } pair_t;

  localparam int PAIR_W = $bits(pair_t);

endpackage

// ----- rtl/mbd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the upper-row pair store of the downsampler. No dependencies.
module mbd_ram #(
  parameter int WIDTH  = 36,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mbd_reduce.sv -----
// Block reduction: adds the upper and lower pair sums of a 2x2 block,
// takes the truncated mean per channel and thresholds alpha. Uses mbd_pkg.
module mbd_reduce import mbd_pkg::*; (
  input  pair_t           upper,
  input  pair_t           lower,
  output logic [CH_W-1:0] red,
  output logic [CH_W-1:0] green,
  output logic [CH_W-1:0] blue,
  output logic [CH_W-1:0] alpha
);

  logic [LANE_W:0] sum_r, sum_g, sum_b, sum_a;
  logic [CH_W-1:0] mean_a;

  // Four-pixel sums; the mean is the sum shifted down by two.
  always_comb begin
    sum_r  = {1'b0, upper.red}   + {1'b0, lower.red};
    sum_g  = {1'b0, upper.green} + {1'b0, lower.green};
    sum_b  = {1'b0, upper.blue}  + {1'b0, lower.blue};
    sum_a  = {1'b0, upper.alpha} + {1'b0, lower.alpha};
    red    = sum_r[LANE_W:2];
    green  = sum_g[LANE_W:2];
    blue   = sum_b[LANE_W:2];
    mean_a = sum_a[LANE_W:2];
    alpha  = (mean_a < ALPHA_THRESH) ? ALPHA_NONE : ALPHA_FULL;
  end

endmodule

// ----- rtl/mipmap_box_downsample.sv -----
// 2x2 box-filter mipmap downsampler, top level.
// Uses mbd_pkg, mbd_ram (upper-row pair store) and mbd_reduce.
//
// Usage: program source_width (byte address 0) and source_height (byte
// address 4) through the APB port while the block is idle, then stream the
// source RGBA pixels in raster order on the in_ channel, one word per clock.
// Each 2x2 block gives one word on the out_ channel when its bottom-right
// pixel arrives; out_final_pixel marks the last word of the output level.
// An odd trailing column or row is consumed without a result, and a source
// narrower or shorter than two pixels gives no words at all.
// Throughput: one pixel per cycle while in_stall is low. The pair-store read
// and the read stage are registered at the edge that accepts the bottom-right
// pixel; the reduction is registered into the output register when it advances.
// Upper-row pair sums are written to the store on even rows and read back
// on odd rows at least two accepted words later, so the registered read
// always sees the finished write and no forwarding path is required.
// Reset clears the counters, the configuration registers and the pipeline valids; the
// store needs no clearing since every entry is written before it is read.
// When the receiver stalls, the output word holds and one more word may
// wait in the read stage; then in_stall rises until the output moves.
module mipmap_box_downsample import mbd_pkg::*; #(
  parameter int MAX_WIDTH = MBD_MAX_WIDTH
) (
  input  logic            clk,
  input  logic            rst_n,
  // Configuration port
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  // Source pixel channel
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [CH_W-1:0] in_red_in,
  input  logic [CH_W-1:0] in_green_in,
  input  logic [CH_W-1:0] in_blue_in,
  input  logic [CH_W-1:0] in_alpha_in,
  // Downsampled pixel channel
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0] out_red_out,
  output logic [CH_W-1:0] out_green_out,
  output logic [CH_W-1:0] out_blue_out,
  output logic [CH_W-1:0] out_alpha_out,
  output logic            out_final_pixel
);

  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);

  // Configuration registers.
  logic [DIM_W-1:0] width_r, height_r;
  logic             cfg_wr;

  // Position counters and the pending left pixel.
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  pair_t             hold_r;

  // Read stage and output register.
  logic              s1_vld_r, s1_vld_nxt;
  pair_t             s1_pair_r;
  logic              s1_final_r;
  logic              out_vld_r, out_vld_nxt;
  logic [CH_W-1:0]   out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic              out_final_r;

  // Datapath signals.
  logic              accept, out_adv;
  logic              col_odd, row_odd, col_end, row_end;
  logic              in_range, is_final;
  logic [HALF_W-1:0] col_half, row_half, out_w, out_h;
  pair_t             pix, pair;
  pair_t             upper;
  logic              st_we, st_re;
  logic [CH_W-1:0]   red_m, green_m, blue_m, alpha_m;

  // APB register writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SRC_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SRC_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_SRC_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_r};
      default:        prdata = '0;
    endcase
  end

  // Handshake: the input waits only when both pipeline slots are full.
  assign out_adv  = ~out_vld_r | ~out_stall;
  assign in_stall = s1_vld_r & ~out_adv;
  assign accept   = in_valid & ~in_stall;

  // Block position of the incoming pixel.
  always_comb begin
    col_odd  = col_r[0];
    row_odd  = row_r[0];
    col_half = col_r[DIM_W-1:1];
    row_half = row_r[DIM_W-1:1];
    out_w    = width_r[DIM_W-1:1];
    out_h    = height_r[DIM_W-1:1];
    col_end  = ({1'b0, col_r} + {{DIM_W{1'b0}}, 1'b1}) >= {1'b0, width_r};
    row_end  = ({1'b0, row_r} + {{DIM_W{1'b0}}, 1'b1}) >= {1'b0, height_r};
    in_range = (col_half < out_w) && (row_half < out_h);
    is_final = (col_half == out_w - HALF_W'(1)) && (row_half == out_h - HALF_W'(1));
  end

  // Pixel widened to lanes and the horizontal pair sum.
  always_comb begin
    pix.red   = {1'b0, in_red_in};
    pix.green = {1'b0, in_green_in};
    pix.blue  = {1'b0, in_blue_in};
    pix.alpha = {1'b0, in_alpha_in};
    pair.red   = hold_r.red   + pix.red;
    pair.green = hold_r.green + pix.green;
    pair.blue  = hold_r.blue  + pix.blue;
    pair.alpha = hold_r.alpha + pix.alpha;
  end

  // Store access: write on even rows, read on odd rows inside the output.
  assign st_we = accept & col_odd & ~row_odd;
  assign st_re = accept & col_odd & row_odd & in_range;

  // Counter update; the store slot follows the column pair index.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (accept) begin
      if (col_end) begin
        col_nxt  = '0;
        slot_nxt = '0;
        row_nxt  = row_end ? '0 : row_r + DIM_W'(1);
      end else begin
        col_nxt = col_r + DIM_W'(1);
        if (col_odd) begin
          slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Left pixel of a pair waits here for its right neighbor.
  always_ff @(posedge clk) begin
    if (accept && !col_odd) begin
      hold_r <= pix;
    end
  end

  // Upper-row pair store.
  mbd_ram #(
    .WIDTH  (PAIR_W),
    .DEPTH  (DEPTH),
    .ADDR_W (SLOT_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (slot_r),
    .wdata (pair),
    .re    (st_re),
    .raddr (slot_r),
    .rdata (upper)
  );

  // Read stage: holds the lower pair while the store read completes.
  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (st_re) begin
      s1_vld_nxt = 1'b1;
    end else if (out_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      s1_pair_r  <= pair;
      s1_final_r <= is_final;
    end
  end

  // Block mean and alpha threshold.
  mbd_reduce u_reduce (
    .upper (upper),
    .lower (s1_pair_r),
    .red   (red_m),
    .green (green_m),
    .blue  (blue_m),
    .alpha (alpha_m)
  );

  // Output register.
  assign out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_vld_r) begin
      out_red_r   <= red_m;
      out_green_r <= green_m;
      out_blue_r  <= blue_m;
      out_alpha_r <= alpha_m;
      out_final_r <= s1_final_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_red_out     = out_red_r;
  assign out_green_out   = out_green_r;
  assign out_blue_out    = out_blue_r;
  assign out_alpha_out   = out_alpha_r;
  assign out_final_pixel = out_final_r;

endmodule

// ----- rtl/mbd_chk.sv -----
// Port-level checker for the mipmap downsampler and its bind statement.
// Uses mbd_pkg; attaches to mipmap_box_downsample.
module mbd_chk import mbd_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CH_W-1:0] out_red_out,
  input logic [CH_W-1:0] out_green_out,
  input logic [CH_W-1:0] out_blue_out,
  input logic [CH_W-1:0] out_alpha_out,
  input logic            out_final_pixel
);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out) &&
      $stable(out_alpha_out) && $stable(out_final_pixel))
    else $error("stalled output word changed");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Alpha leaves the block only fully clear or fully opaque.
  a_alpha_binary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha_out == ALPHA_NONE) || (out_alpha_out == ALPHA_FULL))
    else $error("alpha not thresholded");

  // The input waits only while a finished word is held by the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind mipmap_box_downsample mbd_chk u_mbd_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_red_out     (out_red_out),
  .out_green_out   (out_green_out),
  .out_blue_out    (out_blue_out),
  .out_alpha_out   (out_alpha_out),
  .out_final_pixel (out_final_pixel)
);

// ----- dv/mipmap_box_downsample_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mipmap_box_downsample: a directed table, a wide and a
// tall source level, then random levels, each output word scored by a 2x2 box-filter model.
// Depends on mbd_pkg and the RTL of mipmap_box_downsample.
module mipmap_box_downsample_test;
  import mbd_pkg::*;

  localparam int STORE_SLOTS   = MBD_MAX_WIDTH / 2;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 64;
  localparam int WIDEST_PICK   = 40;
  localparam int TALL_ROWS     = 40;
  localparam int RANDOM_ITEMS  = 860;
  localparam int CALM_AFTER    = 730;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [CH_W-1:0] red, green, blue, alpha;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red, green, blue, alpha;
    logic            last;
  } result_t;

  typedef enum logic {ROW_CONFIG, ROW_PIXEL} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             reg_idx;
    logic [DIM_W-1:0] value;
    pixel_t           px;
    bit               typed;
    result_t          want;
  } stim_row_t;

  // Clock, reset and the configuration port.
  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Source and downsampled pixel channels.
  logic            in_valid  = 1'b0;
  logic            in_stall;
  pixel_t          src_px    = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [CH_W-1:0] out_red_out, out_green_out, out_blue_out, out_alpha_out;
  logic            out_final_pixel;

  // Shadow of the block: registers, raster position, left pixel and upper-row pair sums.
  logic [DIM_W-1:0] cur_width  = '0;
  logic [DIM_W-1:0] cur_height = '0;
  logic [DIM_W-1:0] col_at     = '0;
  logic [DIM_W-1:0] row_at     = '0;
  pair_t            left_pixel = '0;
  pair_t            upper_pairs [STORE_SLOTS];

  result_t pending_words[$];
  int      fault_count = 0;
  bit      calm        = 1'b0;
  int      holds_asked = 0;

  always #10 clk = ~clk;

  mipmap_box_downsample dut (
    .clk,
    .rst_n,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid,
    .in_stall,
    .in_red_in(src_px.red),
    .in_green_in(src_px.green),
    .in_blue_in(src_px.blue),
    .in_alpha_in(src_px.alpha),
    .out_valid,
    .out_stall,
    .out_red_out,
    .out_green_out,
    .out_blue_out,
    .out_alpha_out,
    .out_final_pixel
  );

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("tb: %s", msg);
  endtask

  // Truncated mean of four pixels from an upper pair sum and a lower pair sum.
  function automatic logic [CH_W-1:0] block_mean(input logic [LANE_W-1:0] upper_lane,
                                                 input logic [LANE_W-1:0] lower_lane);
    logic [LANE_W:0] total;
    total = {1'b0, upper_lane} + {1'b0, lower_lane};
    return total[LANE_W:2];
  endfunction

  // Advances the shadow by one source pixel; returns 1 when the pixel completes a block.
  function automatic bit box_filter_predict(input pixel_t px, output result_t word);
    pair_t             here, pair_sum, upper;
    logic [DIM_W-1:0]  half_w, half_h;
    logic [HALF_W-1:0] blk_col, blk_row;
    int                slot;
    bit                made;
    made    = 1'b0;
    word    = '0;
    half_w  = cur_width >> 1;
    half_h  = cur_height >> 1;
    blk_col = col_at[DIM_W-1:1];
    blk_row = row_at[DIM_W-1:1];
    slot    = int'(blk_col) % STORE_SLOTS;
    here.red   = {1'b0, px.red};
    here.green = {1'b0, px.green};
    here.blue  = {1'b0, px.blue};
    here.alpha = {1'b0, px.alpha};
    if (!col_at[0]) begin
      left_pixel = here;
    end else begin
      pair_sum.red   = left_pixel.red + here.red;
      pair_sum.green = left_pixel.green + here.green;
      pair_sum.blue  = left_pixel.blue + here.blue;
      pair_sum.alpha = left_pixel.alpha + here.alpha;
      if (!row_at[0]) begin
        upper_pairs[slot] = pair_sum;
      end else if (blk_col < half_w && blk_row < half_h) begin
        upper      = upper_pairs[slot];
        word.red   = block_mean(upper.red, pair_sum.red);
        word.green = block_mean(upper.green, pair_sum.green);
        word.blue  = block_mean(upper.blue, pair_sum.blue);
        word.alpha = (block_mean(upper.alpha, pair_sum.alpha) < ALPHA_THRESH) ?
                     ALPHA_NONE : ALPHA_FULL;
        word.last  = (blk_col == half_w - 1) && (blk_row == half_h - 1);
        made = 1'b1;
      end
    end
    // Counters wrap at the row end and at the image end, also after a size change.
    if (int'(col_at) + 1 >= int'(cur_width)) begin
      col_at = '0;
      if (int'(row_at) + 1 >= int'(cur_height)) row_at = '0;
      else row_at = row_at + 1'b1;
    end else begin
      col_at = col_at + 1'b1;
    end
    return made;
  endfunction

  // Extremes and values around the alpha threshold come up often.
  function automatic logic [CH_W-1:0] pick_channel(input bit is_alpha);
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3: begin
        if (is_alpha) return 8'($urandom_range(124, 131));
        else return 8'($urandom_range(0, 255));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red   = pick_channel(1'b0);
    px.green = pick_channel(1'b0);
    px.blue  = pick_channel(1'b0);
    px.alpha = pick_channel(1'b1);
    return px;
  endfunction

  // Mostly small levels, now and then degenerate or wider ones.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return DIM_W'($urandom_range(0, 1));
      1: return DIM_W'($urandom_range(17, WIDEST_PICK));
      default: return DIM_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input int value);
    stim_row_t r;
    r.kind    = ROW_CONFIG;
    r.reg_idx = idx;
    r.value   = value[DIM_W-1:0];
    r.px      = '0;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic stim_row_t pix_row(input pixel_t px, input bit typed, input result_t want);
    stim_row_t r;
    r.kind    = ROW_PIXEL;
    r.reg_idx = REG_SRC_WIDTH;
    r.value   = '0;
    r.px      = px;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  // APB write: setup phase, access phase and a readback, after which the bus goes quiet.
  task automatic write_reg(input logic idx, input logic [DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SRC_WIDTH) cur_width = value;
    else cur_height = value;
    @(negedge clk);
    if (prdata !== 32'(value))
      note_fault($sformatf("register %0d readback: expected %0d, got %0d",
                           idx, value, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one source word, waits for it to be taken and records what it should give.
  task automatic send_pixel(input pixel_t px, input bit typed, input result_t want,
                            input bit gappy);
    result_t word;
    bit      made;
    if (gappy && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    src_px   <= px;
    do @(posedge clk); while (in_stall);
    made = box_filter_predict(px, word);
    if (typed) pending_words.push_back(want);
    else if (made) pending_words.push_back(word);
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected word is out and the pipeline has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiver: random stall bursts in some stretches, long holds on request.
  int hold_left    = 0;
  int burst_left   = 0;
  int stretch_left = 0;
  int holds_done   = 0;
  bit stalls_on    = 1'b0;

  always @(negedge clk) begin
    if (stretch_left == 0) begin
      stretch_left <= $urandom_range(40, 300);
      stalls_on    <= $urandom_range(0, 2) != 0;
    end else begin
      stretch_left <= stretch_left - 1;
    end
    if (calm) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall  <= 1'b1;
      hold_left  <= LONG_HOLD - 1;
      holds_done <= holds_done + 1;
    end else if (burst_left != 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each accepted output word is checked against the oldest expected word.
  always @(posedge clk) begin : score_words
    result_t got, want;
    got = '{out_red_out, out_green_out, out_blue_out, out_alpha_out, out_final_pixel};
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        note_fault($sformatf("unexpected word r=%0d g=%0d b=%0d a=%0d last=%0b",
                             got.red, got.green, got.blue, got.alpha, got.last));
      end else begin
        want = pending_words.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.last !== want.last)
          note_fault($sformatf({"word mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0b,",
                                " got r=%0d g=%0d b=%0d a=%0d last=%0b"},
                               want.red, want.green, want.blue, want.alpha, want.last,
                               got.red, got.green, got.blue, got.alpha, got.last));
      end
    end
  end

  initial begin
    stim_row_t        rows[$];
    pixel_t           full, zero;
    result_t          none;
    int               area, count, random_items;
    bit               gappy;
    logic [DIM_W-1:0] w, h;
    full = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    zero = '0;
    none = '0;

    // Registers are zero out of reset, so a pixel gives no word.
    rows.push_back(pix_row('{8'd9, 8'd8, 8'd7, 8'd6}, 1'b0, none));
    rows.push_back(cfg_row(REG_SRC_WIDTH, 2));
    rows.push_back(cfg_row(REG_SRC_HEIGHT, 2));
    // A 2x2 level at full scale and at zero; each block is the last word.
    repeat (3) rows.push_back(pix_row(full, 1'b0, none));
    rows.push_back(pix_row(full, 1'b1, '{8'hFF, 8'hFF, 8'hFF, ALPHA_FULL, 1'b1}));
    repeat (3) rows.push_back(pix_row(zero, 1'b0, none));
    rows.push_back(pix_row(zero, 1'b1, '{8'h00, 8'h00, 8'h00, ALPHA_NONE, 1'b1}));
    // Mean alpha one short of the threshold, with truncated color means.
    rows.push_back(pix_row('{8'd3, 8'd0, 8'd255, 8'd127}, 1'b0, none));
    rows.push_back(pix_row('{8'd3, 8'd0, 8'd255, 8'd128}, 1'b0, none));
    rows.push_back(pix_row('{8'd3, 8'd0, 8'd255, 8'd128}, 1'b0, none));
    rows.push_back(pix_row('{8'd2, 8'd1, 8'd254, 8'd128}, 1'b1,
                           '{8'd2, 8'd0, 8'd254, ALPHA_NONE, 1'b1}));
    // Mean alpha exactly at the threshold.
    rows.push_back(pix_row('{8'd255, 8'd1, 8'd128, 8'd128}, 1'b0, none));
    rows.push_back(pix_row('{8'd0, 8'd1, 8'd128, 8'd128}, 1'b0, none));
    rows.push_back(pix_row('{8'd0, 8'd1, 8'd127, 8'd128}, 1'b0, none));
    rows.push_back(pix_row('{8'd0, 8'd1, 8'd127, 8'd128}, 1'b1,
                           '{8'd63, 8'd1, 8'd127, ALPHA_FULL, 1'b1}));
    // A 3x3 level: the odd trailing column and row are taken without a word.
    rows.push_back(cfg_row(REG_SRC_WIDTH, 3));
    rows.push_back(cfg_row(REG_SRC_HEIGHT, 3));
    for (int k = 0; k < 9; k++)
      rows.push_back(pix_row('{8'(20 * k), 8'(255 - 25 * k), 8'(k), 8'(60 * k)}, 1'b0, none));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CONFIG) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].value);
      end else begin
        send_pixel(rows[i].px, rows[i].typed, rows[i].want, 1'b1);
      end
    end

    // A level as wide as any random one; it writes every store entry those can reach.
    // Partway through the lower row the receiver holds off so the input backs up.
    settle();
    write_reg(REG_SRC_WIDTH, DIM_W'(WIDEST_PICK));
    write_reg(REG_SRC_HEIGHT, 2);
    for (int i = 0; i < 2 * WIDEST_PICK; i++) begin
      if (i == WIDEST_PICK + 4) holds_asked++;
      send_pixel(rand_pixel(), 1'b0, none, 1'b1);
    end

    // A tall source level, two pixels wide.
    settle();
    write_reg(REG_SRC_WIDTH, 2);
    write_reg(REG_SRC_HEIGHT, DIM_W'(TALL_ROWS));
    for (int i = 0; i < 2 * TALL_ROWS; i++) begin
      if (i == 21) holds_asked++;
      send_pixel(rand_pixel(), 1'b0, none, 1'b1);
    end

    // Random levels. Some are cut short, so the next setting lands mid-image;
    // every store entry they can reach is written by now, so no stale entry is read.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      if (random_items >= CALM_AFTER) calm = 1'b1;
      w = pick_dim();
      h = pick_dim();
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
      area = int'(w) * int'(h);
      if (w < 2 || h < 2) count = $urandom_range(3, 30);
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(1, area);
      else if (area <= 120 && $urandom_range(0, 1) == 1) count = 2 * area;
      else count = area;
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      gappy = $urandom_range(0, 3) != 0;
      repeat (count) send_pixel(rand_pixel(), 1'b0, none, gappy);
      random_items += count;
    end

    // Drain with a bound, then let the pipeline run dry.
    in_valid <= 1'b0;
    for (int n = 0; n < 4000 && pending_words.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_words.size() != 0)
      note_fault($sformatf("%0d expected words never arrived", pending_words.size()));
    if (fault_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(25_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mbd_pkg.sv
rtl/mbd_ram.sv
rtl/mbd_reduce.sv
rtl/mipmap_box_downsample.sv
rtl/mbd_chk.sv
dv/mipmap_box_downsample_test.sv
